>>> src/ofr_pkg.sv
package ofr_pkg;

    // Geometry of the ring
    localparam int DEPTH       = 32;
    localparam int AXIS_BITS   = 16;
    localparam int MAX_RESULTS = 32;

    // Fixed widths of the channel fields
    localparam int SAMPLE_W = 16;
    localparam int FUNC_W   = 3;
    localparam int STEPS_W  = 6;
    localparam int IDX_W    = 5;
    localparam int LEN_W    = 6;
    localparam int FILL_W   = 6;
    localparam int TOTAL_W  = 32;

    // Derived widths
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ENTRY_W    = 3 * AXIS_BITS;
    localparam int WRAP_W     = CNT_W + 1;
    localparam int PEEK_SUM_W = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;
    localparam int REW_W      = (CNT_W > STEPS_W) ? CNT_W : STEPS_W;

    typedef logic [PTR_W-1:0]          ptr_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [AXIS_BITS-1:0]      axis_t;
    typedef logic signed [AXIS_BITS-1:0] axis_s_t;
    typedef logic [ENTRY_W-1:0]        entry_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH        = 3'd0,
        FN_POP         = 3'd1,
        FN_DRAIN       = 3'd2,
        FN_PEEK        = 3'd3,
        FN_REWIND      = 3'd4,
        FN_FLUSH       = 3'd5,
        FN_CLR_OVF     = 3'd6,
        FN_RESET_TOTAL = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } state_t;

    // One result item as it travels from the sequencer to the output stage
    typedef struct packed {
        logic                 ok;
        sample_t              out_x;
        sample_t              out_y;
        sample_t              out_z;
        logic [STEPS_W-1:0]   rewound;
        logic [FILL_W-1:0]    fill_count;
        logic                 is_full;
        logic                 overflowed;
        logic [TOTAL_W-1:0]   total_pushed;
        logic                 last;
    } res_t;

    // Keep AXIS_BITS of a sample axis, zero-extending a wider store
    function automatic axis_t to_axis(input logic [SAMPLE_W-1:0] v);
        return AXIS_BITS'(v);
    endfunction

    // Sign-extend (or cut) a stored axis to the output width
    function automatic sample_t from_axis(input axis_t a);
        axis_s_t s;
        s = a;
        return SAMPLE_W'(s);
    endfunction

    // Advance a ring pointer with wrap at DEPTH
    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

endpackage

>>> src/ofr_ram.sv
module ofr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/ofr_ctrl.sv
module ofr_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ofr_pkg::FUNC_W-1:0]          s_func,
    input  logic signed [ofr_pkg::SAMPLE_W-1:0] s_sample_x,
    input  logic signed [ofr_pkg::SAMPLE_W-1:0] s_sample_y,
    input  logic signed [ofr_pkg::SAMPLE_W-1:0] s_sample_z,
    input  logic [ofr_pkg::STEPS_W-1:0]         s_rewind_steps,
    input  logic [ofr_pkg::IDX_W-1:0]           s_peek_index,
    input  logic [ofr_pkg::LEN_W-1:0]           s_max_len,
    output logic                                res_valid,
    input  logic                                res_take,
    output ofr_pkg::res_t                       res,
    output logic                                ram_we,
    output ofr_pkg::ptr_t                       ram_waddr,
    output ofr_pkg::entry_t                     ram_wdata,
    output ofr_pkg::ptr_t                       ram_raddr,
    input  ofr_pkg::entry_t                     ram_rdata
);

    import ofr_pkg::*;

    state_t              state_reg, state_next;
    ptr_t                wr_ptr_reg, wr_ptr_next;
    ptr_t                rd_ptr_reg, rd_ptr_next;
    cnt_t                held_reg, held_next;
    logic                ovf_reg, ovf_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [LEN_W-1:0]    drain_left_reg, drain_left_next;
    logic                last_reg, last_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    logic                res_free;
    logic                load_res;
    logic                use_data;
    logic                r_ok;
    logic                r_last;
    logic [STEPS_W-1:0]  r_rew;
    func_t               func;
    logic [LEN_W-1:0]    drain_lim;
    logic [PEEK_SUM_W-1:0] peek_sum;
    ptr_t                peek_addr;
    cnt_t                valid_cnt;
    cnt_t                rew_max;
    logic [REW_W-1:0]    rew_act_w;
    cnt_t                rew_act;
    logic [WRAP_W-1:0]   back_sum;
    ptr_t                rew_ptr;

    assign func     = func_t'(s_func);
    assign res_free = !res_valid_reg || res_take;

    // Address helpers for peek, rewind and drain
    always_comb begin
        drain_lim = (s_max_len > LEN_W'(MAX_RESULTS)) ? LEN_W'(MAX_RESULTS) : s_max_len;

        peek_sum  = PEEK_SUM_W'(rd_ptr_reg) + PEEK_SUM_W'(s_peek_index);
        peek_addr = (peek_sum >= PEEK_SUM_W'(DEPTH)) ?
                    PTR_W'(peek_sum - PEEK_SUM_W'(DEPTH)) : PTR_W'(peek_sum);

        valid_cnt = (total_reg < TOTAL_W'(DEPTH)) ? CNT_W'(total_reg) : CNT_W'(DEPTH);
        rew_max   = (valid_cnt > held_reg) ? CNT_W'(valid_cnt - held_reg) : '0;
        rew_act_w = (REW_W'(s_rewind_steps) > REW_W'(rew_max)) ?
                    REW_W'(rew_max) : REW_W'(s_rewind_steps);
        rew_act   = CNT_W'(rew_act_w);
        back_sum  = WRAP_W'(rd_ptr_reg) + WRAP_W'(DEPTH) - WRAP_W'(rew_act);
        rew_ptr   = (back_sum >= WRAP_W'(DEPTH)) ?
                    PTR_W'(back_sum - WRAP_W'(DEPTH)) : PTR_W'(back_sum);
    end

    // Sequencer: next state, ring updates and memory accesses
    always_comb begin
        state_next      = state_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        held_next       = held_reg;
        ovf_next        = ovf_reg;
        total_next      = total_reg;
        drain_left_next = drain_left_reg;
        last_next       = last_reg;
        s_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg;
        ram_wdata       = {to_axis(s_sample_z), to_axis(s_sample_y), to_axis(s_sample_x)};
        ram_raddr       = rd_ptr_reg;
        load_res        = 1'b0;
        use_data        = 1'b0;
        r_ok            = 1'b0;
        r_last          = 1'b1;
        r_rew           = '0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = res_free;
                if (s_valid && res_free) begin
                    case (func)
                        FN_PUSH: begin
                            ram_we      = 1'b1;
                            load_res    = 1'b1;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            if (total_reg != '1) begin
                                total_next = total_reg + 1'b1;
                            end
                            if (held_reg < CNT_W'(DEPTH)) begin
                                held_next = held_reg + 1'b1;
                                r_ok      = 1'b1;
                            end else begin
                                rd_ptr_next = ptr_inc(rd_ptr_reg);
                                ovf_next    = 1'b1;
                            end
                        end
                        FN_POP: begin
                            if (held_reg == '0) begin
                                load_res = 1'b1;
                            end else begin
                                rd_ptr_next = ptr_inc(rd_ptr_reg);
                                held_next   = held_reg - 1'b1;
                                last_next   = 1'b1;
                                state_next  = ST_READ;
                            end
                        end
                        FN_DRAIN: begin
                            if (held_reg == '0 || drain_lim == '0) begin
                                load_res = 1'b1;
                            end else begin
                                drain_left_next = drain_lim;
                                state_next      = ST_DRAIN;
                            end
                        end
                        FN_PEEK: begin
                            if (CNT_W'(s_peek_index) >= held_reg ||
                                    (IDX_W > CNT_W && 32'(s_peek_index) >= 32'(held_reg))) begin
                                load_res = 1'b1;
                            end else begin
                                ram_raddr  = peek_addr;
                                last_next  = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        FN_REWIND: begin
                            load_res    = 1'b1;
                            rd_ptr_next = rew_ptr;
                            held_next   = held_reg + rew_act;
                            r_rew       = STEPS_W'(rew_act);
                        end
                        FN_FLUSH: begin
                            load_res    = 1'b1;
                            wr_ptr_next = '0;
                            rd_ptr_next = '0;
                            held_next   = '0;
                            ovf_next    = 1'b0;
                        end
                        FN_CLR_OVF: begin
                            load_res = 1'b1;
                            ovf_next = 1'b0;
                        end
                        FN_RESET_TOTAL: begin
                            load_res   = 1'b1;
                            total_next = '0;
                        end
                        default: begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // Memory data arrives; the result slot is free here
                load_res   = 1'b1;
                use_data   = 1'b1;
                r_ok       = 1'b1;
                r_last     = last_reg;
                state_next = last_reg ? ST_IDLE : ST_DRAIN;
            end
            ST_DRAIN: begin
                // Take the oldest entry once the result slot will be free
                if (res_free) begin
                    rd_ptr_next     = ptr_inc(rd_ptr_reg);
                    held_next       = held_reg - 1'b1;
                    drain_left_next = drain_left_reg - 1'b1;
                    last_next       = (held_reg == CNT_W'(1)) || (drain_left_reg == LEN_W'(1));
                    state_next      = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Build the pending result from the post-operation state
    always_comb begin
        res_next.ok           = r_ok;
        res_next.out_x        = use_data ? from_axis(ram_rdata[AXIS_BITS-1:0]) : '0;
        res_next.out_y        = use_data ? from_axis(ram_rdata[2*AXIS_BITS-1:AXIS_BITS]) : '0;
        res_next.out_z        = use_data ? from_axis(ram_rdata[3*AXIS_BITS-1:2*AXIS_BITS]) : '0;
        res_next.rewound      = r_rew;
        res_next.fill_count   = FILL_W'(held_next);
        res_next.is_full      = (held_next == CNT_W'(DEPTH));
        res_next.overflowed   = ovf_next;
        res_next.total_pushed = total_next;
        res_next.last         = r_last;

        res_valid_next = load_res ? 1'b1 : (res_take ? 1'b0 : res_valid_reg);
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            held_reg       <= '0;
            ovf_reg        <= 1'b0;
            total_reg      <= '0;
            drain_left_reg <= '0;
            last_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            held_reg       <= held_next;
            ovf_reg        <= ovf_next;
            total_reg      <= total_next;
            drain_left_reg <= drain_left_next;
            last_reg       <= last_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load_res) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !res_valid_reg)
        else $error("read data returned with result slot occupied");

    a_drain_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |-> (held_reg != '0 && drain_left_reg != '0))
        else $error("drain running with nothing to take");

    a_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (s_valid && s_ready && state_reg == ST_IDLE))
        else $error("store written outside an accepted push");

    a_pending_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && !res_take |=> res_valid_reg && $stable(res_reg))
        else $error("pending result lost before transfer");

endmodule

>>> src/overwrite_ring_fifo_with_rewind.sv
// Ring FIFO of three-axis samples that overwrites its oldest entry when full.
// Input channel (s_valid/s_ready): one operation per transfer, chosen by
// s_func: push, pop, drain, peek, rewind, flush, clear overflow, reset total.
// Result channel (m_valid/m_ready): one result per operation, except drain,
// which gives one result per entry taken (up to s_max_len, at most 32) and
// marks the final one with m_last; an empty drain gives one result, ok low.
// A result passes through the sequencer's result stage and then the output
// register; pop and peek first read the sample memory, whose read port is
// registered. Push, rewind, flush and the flag operations complete in the
// idle state; pop and peek hold off input while the memory is read; drain
// holds it off for each entry taken, each a memory read followed by loading
// the result stage.
// Reset clears the pointers, fill count, overflow flag and push total, not the
// sample memory; the block does not ensure an entry is only read after it was written.
// When the receiver stalls, one result waits in the output register and one
// more in the sequencer's result stage; input is then held off.
module overwrite_ring_fifo_with_rewind (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ofr_pkg::FUNC_W-1:0]          s_func,
    input  logic signed [ofr_pkg::SAMPLE_W-1:0] s_sample_x,
    input  logic signed [ofr_pkg::SAMPLE_W-1:0] s_sample_y,
    input  logic signed [ofr_pkg::SAMPLE_W-1:0] s_sample_z,
    input  logic [ofr_pkg::STEPS_W-1:0]         s_rewind_steps,
    input  logic [ofr_pkg::IDX_W-1:0]           s_peek_index,
    input  logic [ofr_pkg::LEN_W-1:0]           s_max_len,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_ok,
    output logic signed [ofr_pkg::SAMPLE_W-1:0] m_out_x,
    output logic signed [ofr_pkg::SAMPLE_W-1:0] m_out_y,
    output logic signed [ofr_pkg::SAMPLE_W-1:0] m_out_z,
    output logic [ofr_pkg::STEPS_W-1:0]         m_rewound,
    output logic [ofr_pkg::FILL_W-1:0]          m_fill_count,
    output logic                                m_is_full,
    output logic                                m_overflowed,
    output logic [ofr_pkg::TOTAL_W-1:0]         m_total_pushed,
    output logic                                m_last
);

    import ofr_pkg::*;

    logic    res_valid;
    logic    res_take;
    res_t    res;
    logic    ram_we;
    ptr_t    ram_waddr;
    entry_t  ram_wdata;
    ptr_t    ram_raddr;
    entry_t  ram_rdata;

    logic    m_valid_reg, m_valid_next;
    res_t    m_res_reg;
    logic    out_free;

    ofr_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_sample_x     (s_sample_x),
        .s_sample_y     (s_sample_y),
        .s_sample_z     (s_sample_z),
        .s_rewind_steps (s_rewind_steps),
        .s_peek_index   (s_peek_index),
        .s_max_len      (s_max_len),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    ofr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Output register: take a result whenever the slot is empty or draining
    assign out_free     = !m_valid_reg || m_ready;
    assign res_take     = res_valid && out_free;
    assign m_valid_next = res_take ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = m_res_reg.ok;
    assign m_out_x        = m_res_reg.out_x;
    assign m_out_y        = m_res_reg.out_y;
    assign m_out_z        = m_res_reg.out_z;
    assign m_rewound      = m_res_reg.rewound;
    assign m_fill_count   = m_res_reg.fill_count;
    assign m_is_full      = m_res_reg.is_full;
    assign m_overflowed   = m_res_reg.overflowed;
    assign m_total_pushed = m_res_reg.total_pushed;
    assign m_last         = m_res_reg.last;

endmodule
